>>> hdl/packet_stats_counter_unit_macros.svh
// Assertion macros used by the packet statistics RTL.
`ifndef PACKET_STATS_COUNTER_UNIT_MACROS_SVH
`define PACKET_STATS_COUNTER_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PSC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/psc_pkg.sv
// Types and constants for the packet statistics counter unit.
`default_nettype none

package psc_pkg;

   localparam int PORT_SLOTS_DEFAULT = 256;
   localparam int COUNT_BITS_DEFAULT = 64;

   localparam int CLASS_NUM  = 6;
   localparam int BUCKET_NUM = 7;

   // minimum frame lengths: Ethernet header, plus IPv4 / IPv6 base header
   localparam logic [15:0] MIN_ETH_LEN  = 16'd14;
   localparam logic [15:0] MIN_IPV4_LEN = 16'd34;
   localparam logic [15:0] MIN_IPV6_LEN = 16'd54;

   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
   localparam logic [15:0] ETYPE_ARP  = 16'h0806;

   localparam logic [7:0] NH_ICMP   = 8'd1;
   localparam logic [7:0] NH_TCP    = 8'd6;
   localparam logic [7:0] NH_UDP    = 8'd17;
   localparam logic [7:0] NH_ICMPV6 = 8'd58;

   localparam logic [BUCKET_NUM-2:0][15:0] BUCKET_LIMITS =
      {16'd1518, 16'd1024, 16'd512, 16'd256, 16'd128, 16'd64};

   typedef enum logic [2:0] {
      CLS_TCP   = 3'd0,
      CLS_UDP   = 3'd1,
      CLS_ICMP  = 3'd2,
      CLS_OTHER = 3'd3,
      CLS_ARP   = 3'd4,
      CLS_IPV6  = 3'd5
   } class_code_type;

   typedef logic [63:0] count_out_type;

   typedef struct packed {
      logic [15:0] frame_length;
      logic [15:0] ether_type;
      logic [7:0]  next_protocol;
      logic [7:0]  interface_index;
   } req_type;

   typedef struct packed {
      logic          counted;
      logic [2:0]    class_code;
      logic [2:0]    size_bucket;
      count_out_type total_packets;
      count_out_type total_bytes;
      count_out_type class_packets;
      count_out_type class_bytes;
      count_out_type bucket_count;
      count_out_type port_packets;
      count_out_type port_bytes;
   } rsp_type;

endpackage

`default_nettype wire

>>> hdl/packet_stats_counter_unit.sv
// Packet statistics counter unit: classifies descriptors and updates wrapping counters.
// An accepted descriptor is held in s1, then loaded into the result register.
// Throughput: one beat per cycle while req_stall is low; RAM reads are registered, and
//   updates to the same interface in flight are forwarded from the last two writes.
// Reset: all counters clear; the interface RAM is then swept to zero, one entry per
//   cycle, and req_stall stays high for that sweep.
`default_nettype none

module packet_stats_counter_unit #(
   parameter int PORT_SLOTS = psc_pkg::PORT_SLOTS_DEFAULT,
   parameter int COUNT_BITS = psc_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire psc_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      psc_pkg::rsp_type rsp_data
);
   import psc_pkg::*;

   localparam int PORT_W = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;

   // interface_index modulo PORT_SLOTS, as a 256-entry constant table
   function automatic logic [255:0][11:0] build_slot_table(input int slots);
      logic [255:0][11:0] tab;
      int                 r;
      r = 0;
      for (int i = 0; i < 256; i++) begin
         tab[i] = 12'(r);
         r = r + 1;
         if (r == slots) begin
            r = 0;
         end
      end
      return tab;
   endfunction

   localparam logic [255:0][11:0] SLOT_TABLE = build_slot_table(PORT_SLOTS);

   function automatic class_code_type classify(input logic [15:0] len,
                                               input logic [15:0] etype,
                                               input logic [7:0]  proto);
      class_code_type c;
      c = CLS_OTHER;
      if (etype == ETYPE_IPV4) begin
         if (len < MIN_IPV4_LEN)          c = CLS_OTHER;
         else if (proto == NH_TCP)        c = CLS_TCP;
         else if (proto == NH_UDP)        c = CLS_UDP;
         else if (proto == NH_ICMP)       c = CLS_ICMP;
         else                             c = CLS_OTHER;
      end else if (etype == ETYPE_IPV6) begin
         if (len < MIN_IPV6_LEN)          c = CLS_IPV6;
         else if (proto == NH_TCP)        c = CLS_TCP;
         else if (proto == NH_UDP)        c = CLS_UDP;
         else if (proto == NH_ICMPV6)     c = CLS_ICMP;
         else                             c = CLS_IPV6;
      end else if (etype == ETYPE_ARP) begin
         c = CLS_ARP;
      end
      return c;
   endfunction

   function automatic logic [2:0] size_bucket_of(input logic [15:0] len);
      logic [2:0] b;
      b = 3'(BUCKET_NUM - 1);
      for (int i = BUCKET_NUM - 2; i >= 0; i--) begin
         if (len < BUCKET_LIMITS[i]) begin
            b = 3'(i);
         end
      end
      return b;
   endfunction

   // ---------------------------------------------------------------------
   // Control and handshake
   // ---------------------------------------------------------------------
   logic                  clear_ff, clear_in;       // RAM sweep after reset
   logic [PORT_W-1:0]     clr_idx_ff, clr_idx_in;

   logic                  s1_vld_ff;                // descriptor waiting on RAM data
   logic                  s1_counted_ff;
   logic [15:0]           s1_len_ff;
   class_code_type        s1_cls_ff;
   logic [2:0]            s1_bkt_ff;
   logic [PORT_W-1:0]     s1_port_ff;

   logic                  rsp_vld_ff;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  req_accept;
   logic                  s1_adv;

   // s1 moves into the result register when that register is empty or draining
   assign s1_adv     = s1_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall  = clear_ff || (s1_vld_ff && !s1_adv);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_vld_ff;
   assign rsp_data   = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Stage 0: classify, pick the interface slot, issue the RAM read
   // ---------------------------------------------------------------------
   logic [11:0]       slot_raw;
   logic [PORT_W-1:0] req_port;
   class_code_type    req_cls;
   logic [2:0]        req_bkt;
   logic              req_counted;

   always_comb begin
      slot_raw    = SLOT_TABLE[req_data.interface_index];
      req_port    = slot_raw[PORT_W-1:0];
      req_cls     = classify(req_data.frame_length, req_data.ether_type,
                             req_data.next_protocol);
      req_bkt     = size_bucket_of(req_data.frame_length);
      req_counted = (req_data.frame_length >= MIN_ETH_LEN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_accept) begin
         s1_vld_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_counted_ff <= req_counted;
         s1_len_ff     <= req_data.frame_length;
         s1_cls_ff     <= req_cls;
         s1_bkt_ff     <= req_bkt;
         s1_port_ff    <= req_port;
      end
   end

   // ---------------------------------------------------------------------
   // Per-interface counter RAM: {packets, bytes}, registered read
   // ---------------------------------------------------------------------
   logic [2*COUNT_BITS-1:0] port_mem [PORT_SLOTS];
   logic [2*COUNT_BITS-1:0] rd_ff;
   logic                    mem_we;
   logic [PORT_W-1:0]       mem_wa;
   logic [2*COUNT_BITS-1:0] mem_wd;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_ff <= port_mem[req_port];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         port_mem[mem_wa] <= mem_wd;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: read-modify-write of all counters
   // ---------------------------------------------------------------------
   logic [COUNT_BITS-1:0] glb_pkts_ff, glb_pkts_in;
   logic [COUNT_BITS-1:0] glb_bytes_ff, glb_bytes_in;
   logic [COUNT_BITS-1:0] cls_pkts_ff  [CLASS_NUM];
   logic [COUNT_BITS-1:0] cls_bytes_ff [CLASS_NUM];
   logic [COUNT_BITS-1:0] bkt_cnt_ff   [BUCKET_NUM];
   logic [COUNT_BITS-1:0] cls_pkts_in, cls_bytes_in, bkt_cnt_in;

   // the two most recent RAM update writes; a read issued before either
   // landed sees stale data, so a matching slot takes the newer copy
   logic                  fwd1_vld_ff, fwd2_vld_ff;
   logic [PORT_W-1:0]     fwd1_port_ff, fwd2_port_ff;
   logic [COUNT_BITS-1:0] fwd1_pkts_ff, fwd2_pkts_ff;
   logic [COUNT_BITS-1:0] fwd1_bytes_ff, fwd2_bytes_ff;

   logic [COUNT_BITS-1:0] port_pkts_base, port_bytes_base;
   logic [COUNT_BITS-1:0] port_pkts_in, port_bytes_in;
   logic [COUNT_BITS-1:0] len_ext;
   logic                  upd;

   assign upd = s1_adv && s1_counted_ff;

   always_comb begin
      len_ext = {{(COUNT_BITS-16){1'b0}}, s1_len_ff};

      if (fwd1_vld_ff && (fwd1_port_ff == s1_port_ff)) begin
         port_pkts_base  = fwd1_pkts_ff;
         port_bytes_base = fwd1_bytes_ff;
      end else if (fwd2_vld_ff && (fwd2_port_ff == s1_port_ff)) begin
         port_pkts_base  = fwd2_pkts_ff;
         port_bytes_base = fwd2_bytes_ff;
      end else begin
         port_pkts_base  = rd_ff[2*COUNT_BITS-1:COUNT_BITS];
         port_bytes_base = rd_ff[COUNT_BITS-1:0];
      end

      glb_pkts_in   = glb_pkts_ff + COUNT_BITS'(1);
      glb_bytes_in  = glb_bytes_ff + len_ext;
      cls_pkts_in   = cls_pkts_ff[s1_cls_ff] + COUNT_BITS'(1);
      cls_bytes_in  = cls_bytes_ff[s1_cls_ff] + len_ext;
      bkt_cnt_in    = bkt_cnt_ff[s1_bkt_ff] + COUNT_BITS'(1);
      port_pkts_in  = port_pkts_base + COUNT_BITS'(1);
      port_bytes_in = port_bytes_base + len_ext;

      // runt frames report all zeros
      rsp_data_in = '0;
      if (s1_counted_ff) begin
         rsp_data_in.counted       = 1'b1;
         rsp_data_in.class_code    = s1_cls_ff;
         rsp_data_in.size_bucket   = s1_bkt_ff;
         rsp_data_in.total_packets = count_out_type'(glb_pkts_in);
         rsp_data_in.total_bytes   = count_out_type'(glb_bytes_in);
         rsp_data_in.class_packets = count_out_type'(cls_pkts_in);
         rsp_data_in.class_bytes   = count_out_type'(cls_bytes_in);
         rsp_data_in.bucket_count  = count_out_type'(bkt_cnt_in);
         rsp_data_in.port_packets  = count_out_type'(port_pkts_in);
         rsp_data_in.port_bytes    = count_out_type'(port_bytes_in);
      end
   end

   // RAM write port: sweep after reset, then counter updates
   always_comb begin
      mem_we = clear_ff || upd;
      mem_wa = clear_ff ? clr_idx_ff : s1_port_ff;
      mem_wd = clear_ff ? '0 : {port_pkts_in, port_bytes_in};
   end

   always_comb begin
      clear_in   = clear_ff;
      clr_idx_in = clr_idx_ff;
      if (clear_ff) begin
         if (clr_idx_ff == PORT_W'(PORT_SLOTS - 1)) begin
            clear_in = 1'b0;
         end else begin
            clr_idx_in = clr_idx_ff + PORT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff   <= 1'b1;
         clr_idx_ff <= '0;
      end else begin
         clear_ff   <= clear_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         glb_pkts_ff  <= '0;
         glb_bytes_ff <= '0;
         for (int i = 0; i < CLASS_NUM; i++) begin
            cls_pkts_ff[i]  <= '0;
            cls_bytes_ff[i] <= '0;
         end
         for (int i = 0; i < BUCKET_NUM; i++) begin
            bkt_cnt_ff[i] <= '0;
         end
      end else if (upd) begin
         glb_pkts_ff             <= glb_pkts_in;
         glb_bytes_ff            <= glb_bytes_in;
         cls_pkts_ff[s1_cls_ff]  <= cls_pkts_in;
         cls_bytes_ff[s1_cls_ff] <= cls_bytes_in;
         bkt_cnt_ff[s1_bkt_ff]   <= bkt_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd1_vld_ff <= 1'b0;
         fwd2_vld_ff <= 1'b0;
      end else if (upd) begin
         fwd1_vld_ff <= 1'b1;
         fwd2_vld_ff <= fwd1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (upd) begin
         fwd1_port_ff  <= s1_port_ff;
         fwd1_pkts_ff  <= port_pkts_in;
         fwd1_bytes_ff <= port_bytes_in;
         fwd2_port_ff  <= fwd1_port_ff;
         fwd2_pkts_ff  <= fwd1_pkts_ff;
         fwd2_bytes_ff <= fwd1_bytes_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
`include "packet_stats_counter_unit_macros.svh"

   `PSC_ASSERT_NOW(a_no_work_in_sweep, clear_ff, !s1_vld_ff && !upd, "update during RAM sweep")
   `PSC_ASSERT_NEXT(a_glb_step, upd, glb_pkts_ff == $past(glb_pkts_ff) + COUNT_BITS'(1), "global count step")
   `PSC_ASSERT_NEXT(a_s1_hold, s1_vld_ff && !s1_adv, s1_vld_ff && $stable(s1_port_ff) && $stable(rd_ff), "stage 1 lost while held")
   `PSC_ASSERT_NEXT(a_rsp_follows, s1_adv, rsp_vld_ff && (rsp_data_ff.counted == $past(s1_counted_ff)), "result not loaded")

endmodule

`default_nettype wire

>>> tb/packet_stats_counter_checker.sv
// Scoreboard for the packet statistics counter: mirrors every counter and checks each result beat.
module packet_stats_counter_checker
   import psc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      awaiting
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = PORT_SLOTS_DEFAULT;

   logic [63:0] all_packets;
   logic [63:0] all_bytes;
   logic [63:0] class_pkts   [CLASS_NUM];
   logic [63:0] class_octets [CLASS_NUM];
   logic [63:0] bucket_hits  [BUCKET_NUM];
   logic [63:0] port_pkts    [SLOTS];
   logic [63:0] port_octets  [SLOTS];

   // counts the block owes us, oldest first
   rsp_type counts_due [$];

   function automatic class_code_type traffic_kind(req_type d);
      class_code_type kind;
      kind = CLS_OTHER;
      if (d.ether_type == ETYPE_IPV4) begin
         // short IPv4 header stays "other"
         if (d.frame_length >= MIN_IPV4_LEN) begin
            case (d.next_protocol)
               NH_TCP:  kind = CLS_TCP;
               NH_UDP:  kind = CLS_UDP;
               NH_ICMP: kind = CLS_ICMP;
               default: kind = CLS_OTHER;
            endcase
         end
      end else if (d.ether_type == ETYPE_IPV6) begin
         kind = CLS_IPV6;
         if (d.frame_length >= MIN_IPV6_LEN) begin
            case (d.next_protocol)
               NH_TCP:    kind = CLS_TCP;
               NH_UDP:    kind = CLS_UDP;
               NH_ICMPV6: kind = CLS_ICMP;
               default:   kind = CLS_IPV6;
            endcase
         end
      end else if (d.ether_type == ETYPE_ARP) begin
         kind = CLS_ARP;
      end
      return kind;
   endfunction

   function automatic logic [2:0] size_bin(logic [15:0] len);
      logic [2:0] bin;
      bin = 3'(BUCKET_NUM - 1);
      for (int b = BUCKET_NUM - 2; b >= 0; b--) begin
         if (len < BUCKET_LIMITS[b]) bin = 3'(b);
      end
      return bin;
   endfunction

   // Applies one descriptor to the mirrored counters and returns the counts it should report.
   function automatic rsp_type count_descriptor(req_type d);
      rsp_type        r;
      class_code_type kind;
      logic [2:0]     bin;
      int             slot;
      r = '0;
      if (d.frame_length >= MIN_ETH_LEN) begin
         kind = traffic_kind(d);
         bin  = size_bin(d.frame_length);
         slot = int'(d.interface_index) % SLOTS;
         all_packets        += 64'd1;
         all_bytes          += 64'(d.frame_length);
         class_pkts[kind]   += 64'd1;
         class_octets[kind] += 64'(d.frame_length);
         bucket_hits[bin]   += 64'd1;
         port_pkts[slot]    += 64'd1;
         port_octets[slot]  += 64'(d.frame_length);
         r.counted       = 1'b1;
         r.class_code    = kind;
         r.size_bucket   = bin;
         r.total_packets = all_packets;
         r.total_bytes   = all_bytes;
         r.class_packets = class_pkts[kind];
         r.class_bytes   = class_octets[kind];
         r.bucket_count  = bucket_hits[bin];
         r.port_packets  = port_pkts[slot];
         r.port_bytes    = port_octets[slot];
      end
      return r;
   endfunction

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         $display("t=%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         all_packets = '0;
         all_bytes   = '0;
         foreach (class_pkts[i]) begin
            class_pkts[i]   = '0;
            class_octets[i] = '0;
         end
         foreach (bucket_hits[i]) bucket_hits[i] = '0;
         foreach (port_pkts[i]) begin
            port_pkts[i]   = '0;
            port_octets[i] = '0;
         end
         counts_due.delete();
      end else begin
         // result first: a beat leaving this edge belongs to an earlier descriptor
         if (rsp_valid && !rsp_stall) begin
            if (counts_due.size() == 0) begin
               mismatches++;
               $display("t=%0t: result beat expected none, got %p", $time, rsp_data);
            end else begin
               want = counts_due.pop_front();
               check_field("counted",       64'(want.counted),     64'(rsp_data.counted));
               check_field("class_code",    64'(want.class_code),  64'(rsp_data.class_code));
               check_field("size_bucket",   64'(want.size_bucket), 64'(rsp_data.size_bucket));
               check_field("total_packets", want.total_packets,    rsp_data.total_packets);
               check_field("total_bytes",   want.total_bytes,      rsp_data.total_bytes);
               check_field("class_packets", want.class_packets,    rsp_data.class_packets);
               check_field("class_bytes",   want.class_bytes,      rsp_data.class_bytes);
               check_field("bucket_count",  want.bucket_count,     rsp_data.bucket_count);
               check_field("port_packets",  want.port_packets,     rsp_data.port_packets);
               check_field("port_bytes",    want.port_bytes,       rsp_data.port_bytes);
            end
         end
         if (req_valid && !req_stall) counts_due.push_back(count_descriptor(req_data));
      end
      awaiting <= counts_due.size();
   end

endmodule

>>> tb/tb_packet_stats_counter_unit.sv
// Testbench top for the packet statistics counter unit: clock, reset, descriptor and stall traffic.
module tb_packet_stats_counter_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import psc_pkg::*;

   // random descriptor count after the directed list
   localparam int RANDOM_BEATS     = 1030;
   // receiver hold-off, long enough that the pipeline backs up into req_stall
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int LONG_HOLD_BEATS  = 60;
   // points in the random stream for the hold-off and the full drain
   localparam int HOLD_AT          = 300;
   localparam int DRAIN_AT         = 650;
   // quiet cycles after the last result, as a margin before finishing
   localparam int TAIL_CYCLES      = 10;
   // cycles without any beat before giving up; covers the 256-entry sweep after
   // reset and the long hold-off several times over
   localparam int STALL_LIMIT      = 3000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int      mismatch_count;
   int      counts_awaited;
   // set by the sender, cleared by the receiver once the hold-off is over
   bit      long_hold_armed;

   packet_stats_counter_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   packet_stats_counter_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .mismatches (mismatch_count),
      .awaiting   (counts_awaited)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic req_type make_desc(input logic [15:0] len, input logic [15:0] etype,
                                         input logic [7:0] proto, input logic [7:0] port);
      req_type d;
      d.frame_length    = len;
      d.ether_type      = etype;
      d.next_protocol   = proto;
      d.interface_index = port;
      return d;
   endfunction

   // Lengths right at the runt, header-truncation and histogram limits.
   function automatic logic [15:0] boundary_length();
      case ($urandom_range(0, 16))
         0:       return 16'd14;
         1:       return 16'd33;
         2:       return 16'd34;
         3:       return 16'd53;
         4:       return 16'd54;
         5:       return 16'd63;
         6:       return 16'd64;
         7:       return 16'd127;
         8:       return 16'd128;
         9:       return 16'd255;
         10:      return 16'd256;
         11:      return 16'd511;
         12:      return 16'd512;
         13:      return 16'd1023;
         14:      return 16'd1024;
         15:      return 16'd1517;
         default: return 16'd1518;
      endcase
   endfunction

   // Mostly plausible traffic: known ethertypes and protocols, realistic lengths, and a
   // few hot interfaces so back-to-back updates to one counter pair are common.
   function automatic req_type random_desc();
      req_type d;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < 5)       d.frame_length = 16'($urandom_range(0, 13));
      else if (pick < 15) d.frame_length = boundary_length();
      else if (pick < 25) d.frame_length = 16'($urandom());
      else                d.frame_length = 16'($urandom_range(14, 1600));

      pick = $urandom_range(0, 99);
      if (pick < 40)      d.ether_type = ETYPE_IPV4;
      else if (pick < 70) d.ether_type = ETYPE_IPV6;
      else if (pick < 80) d.ether_type = ETYPE_ARP;
      else                d.ether_type = 16'($urandom());

      pick = $urandom_range(0, 99);
      if (pick < 25)      d.next_protocol = NH_TCP;
      else if (pick < 45) d.next_protocol = NH_UDP;
      else if (pick < 55) d.next_protocol = NH_ICMP;
      else if (pick < 65) d.next_protocol = NH_ICMPV6;
      else                d.next_protocol = 8'($urandom_range(0, 255));

      if ($urandom_range(0, 99) < 40) d.interface_index = 8'($urandom_range(0, 3));
      else                            d.interface_index = 8'($urandom_range(0, 255));
      return d;
   endfunction

   // Offer one beat from a falling edge and hold it until taken; returns on the
   // next falling edge with valid still high, so the caller either sends again
   // or drops valid, never both in one step.
   task automatic send_beat(input req_type beat);
      req_data  <= beat;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic sender_gap(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Back-to-back directed beats: runts, header truncation, every class, every
   // bucket limit, extreme field values and both ends of the interface range.
   task automatic send_directed();
      send_beat(make_desc(16'd0,     ETYPE_IPV4, NH_TCP,    8'd0));
      send_beat(make_desc(16'd13,    16'hFFFF,   8'hFF,     8'hFF));
      send_beat(make_desc(16'd14,    ETYPE_IPV4, NH_TCP,    8'd0));
      send_beat(make_desc(16'd33,    ETYPE_IPV4, NH_UDP,    8'd1));
      send_beat(make_desc(16'd34,    ETYPE_IPV4, NH_TCP,    8'd0));
      send_beat(make_desc(16'd63,    ETYPE_IPV4, NH_UDP,    8'd0));
      send_beat(make_desc(16'd64,    ETYPE_IPV4, NH_ICMP,   8'd255));
      send_beat(make_desc(16'd127,   ETYPE_IPV4, NH_ICMPV6, 8'd255));
      send_beat(make_desc(16'd128,   ETYPE_IPV6, NH_TCP,    8'd7));
      send_beat(make_desc(16'd53,    ETYPE_IPV6, NH_UDP,    8'd7));
      send_beat(make_desc(16'd54,    ETYPE_IPV6, NH_UDP,    8'd7));
      send_beat(make_desc(16'd255,   ETYPE_IPV6, NH_ICMPV6, 8'd7));
      send_beat(make_desc(16'd256,   ETYPE_IPV6, NH_ICMP,   8'd7));
      send_beat(make_desc(16'd511,   ETYPE_ARP,  8'h00,     8'd128));
      send_beat(make_desc(16'd512,   ETYPE_ARP,  8'hFF,     8'd128));
      send_beat(make_desc(16'd1023,  16'h0000,   NH_TCP,    8'd1));
      send_beat(make_desc(16'd1024,  16'hFFFF,   NH_UDP,    8'd2));
      send_beat(make_desc(16'd1517,  16'h0801,   NH_TCP,    8'd3));
      send_beat(make_desc(16'd1518,  16'h86DC,   NH_TCP,    8'd4));
      send_beat(make_desc(16'd65535, ETYPE_IPV4, NH_TCP,    8'd255));
      send_beat(make_desc(16'd65535, ETYPE_IPV6, 8'hFF,     8'd0));
      send_beat(make_desc(16'd14,    ETYPE_ARP,  8'h00,     8'd0));
   endtask

   // Sender: reset, directed list, then bursts of random descriptors with gaps.
   initial begin : stimulus
      int sent;
      int burst;
      bit hold_done;
      bit drain_done;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      long_hold_armed = 1'b0;
      sent            = 0;
      hold_done       = 1'b0;
      drain_done      = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // req_stall covers the interface RAM sweep; send_beat just waits it out

      send_directed();

      while (sent < RANDOM_BEATS) begin
         if (!hold_done && sent >= HOLD_AT) begin
            // keep offering while the receiver holds off, so the unit backs up
            hold_done       = 1'b1;
            long_hold_armed = 1'b1;
            repeat (LONG_HOLD_BEATS) send_beat(random_desc());
            sent += LONG_HOLD_BEATS;
         end else if (!drain_done && sent >= DRAIN_AT) begin
            // stop until every outstanding result has come back
            drain_done = 1'b1;
            req_valid <= 1'b0;
            while (counts_awaited != 0) @(negedge clock);
         end else begin
            burst = $urandom_range(1, 40);
            repeat (burst) send_beat(random_desc());
            sent += burst;
            // about a quarter of bursts run straight into the next one
            if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 8));
         end
      end

      req_valid <= 1'b0;
      while (counts_awaited != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Receiver: stretches of random length, each with its own stall pattern,
   // plus the one long hold-off that the sender arms.
   initial begin : receiver
      int stretch_left;
      int mode;
      rsp_stall    = 1'b0;
      stretch_left = 0;
      mode         = 0;
      forever begin
         @(negedge clock);
         if (long_hold_armed) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            long_hold_armed = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            if (stretch_left == 0) begin
               mode         = $urandom_range(0, 3);
               stretch_left = $urandom_range(4, 64);
            end
            stretch_left--;
            case (mode)
               0:       rsp_stall <= 1'b0;                            // free flow
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);     // light
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);     // heavy
               default: rsp_stall <= stretch_left[0];                 // alternating
            endcase
         end
      end
   end

   // Watchdog: ends the run if no beat moves on either channel for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("end of test: mismatches");
      $finish;
   end

endmodule
